### rtl/core/mks_pkg.sv
// Package for the matrix keypad scanner: field widths, defaults, codes and shared types.
// No dependencies; every other file of the block imports it.
package mks_pkg;

    localparam int MKS_ROWS = 4;
    localparam int MKS_COLS = 4;

    localparam int COL_W      = 4;
    localparam int ROW_W      = 4;
    localparam int CODE_W     = 4;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_DATA_W-1:0] SCAN_PERIOD_RST   = 16'd50;
    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_TIME_RST = 16'd5;

    localparam logic [CFG_ADDR_W-1:0] REG_SCAN_PERIOD   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_TIME = 1'b1;

    typedef enum logic [1:0] {
        PH_SCAN     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_RELEASE  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row_drive;
        logic              key_valid;
        logic [CODE_W-1:0] key_code;
    } mks_result_t;

endpackage

### rtl/core/mks_if.sv
// Request channel interfaces of the keypad scanner: column samples in, key results out.
// Depends on mks_pkg for the field widths.
interface mks_in_if import mks_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] column_levels;

    modport source (output valid, output column_levels, input ready);
    modport sink (input valid, input column_levels, output ready);
endinterface

interface mks_out_if import mks_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  row_drive;
    logic              key_valid;
    logic [CODE_W-1:0] key_code;

    modport source (output valid, output row_drive, output key_valid, output key_code,
                    input ready);
    modport sink (input valid, input row_drive, input key_valid, input key_code,
                  output ready);
endinterface

### rtl/core/mks_scan_core.sv
// Scan and debounce state machine of the keypad scanner, advanced once per accepted sample.
// Depends on mks_pkg for the phase type and the result struct.
module mks_scan_core import mks_pkg::*; #(
    parameter int ROWS = MKS_ROWS,
    parameter int COLS = MKS_COLS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [CFG_DATA_W-1:0] scan_period,
    input  logic [CFG_DATA_W-1:0] debounce_time,
    input  logic [COL_W-1:0]      column_levels,
    output mks_result_t           result
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);
    localparam int UC = (COLS < COL_W) ? COLS : COL_W;
    localparam logic [COL_W-1:0] COL_MASK = COL_W'((1 << UC) - 1);

    phase_t                phase_reg, phase_next;
    logic [RW-1:0]         active_row_reg, active_row_next;
    logic [CFG_DATA_W-1:0] tick_reg, tick_next;
    logic [CW-1:0]         held_column_reg, held_column_next;
    logic [COL_W-1:0]      prev_cols_reg;

    logic [COL_W-1:0]  cols;
    logic [COL_W-1:0]  fell;
    logic [CW-1:0]     fell_index;
    logic              held_bit;
    logic              debounce_done;
    logic              period_done;
    logic [31:0]       code_full;

    assign cols          = column_levels & COL_MASK;
    assign fell          = prev_cols_reg & ~cols & COL_MASK;
    assign debounce_done = (tick_reg >= debounce_time);
    assign period_done   = ({1'b0, tick_reg} + 17'd1) >= {1'b0, scan_period};

    always_comb
    begin
        held_bit   = 1'b0;
        fell_index = '0;
        for (int i = 0; i < COL_W; i++)
        begin
            if (32'(held_column_reg) == 32'(i))
            begin
                held_bit = cols[i];
            end
        end
        for (int i = COL_W - 1; i >= 0; i--)
        begin
            if (fell[i])
            begin
                fell_index = CW'(i);
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_DEBOUNCE:
            begin
                if (debounce_done)
                begin
                    phase_next = held_bit ? PH_SCAN : PH_RELEASE;
                end
            end
            PH_RELEASE:
            begin
                if (held_bit)
                begin
                    phase_next = PH_SCAN;
                end
            end
            default:
            begin
                phase_next = (fell != '0) ? PH_DEBOUNCE : PH_SCAN;
            end
        endcase
    end

    always_comb
    begin
        tick_next        = tick_reg;
        active_row_next  = active_row_reg;
        held_column_next = held_column_reg;
        result.key_valid = 1'b0;
        unique case (phase_reg)
            PH_DEBOUNCE:
            begin
                tick_next = debounce_done ? '0 : tick_reg + 16'd1;
            end
            PH_RELEASE:
            begin
                if (held_bit)
                begin
                    result.key_valid = 1'b1;
                    tick_next        = '0;
                end
            end
            default:
            begin
                if (fell != '0)
                begin
                    held_column_next = fell_index;
                    tick_next        = '0;
                end
                else if (period_done)
                begin
                    tick_next = '0;
                    if (32'(active_row_reg) + 32'd1 >= 32'(ROWS))
                    begin
                        active_row_next = '0;
                    end
                    else
                    begin
                        active_row_next = active_row_reg + RW'(1);
                    end
                end
                else
                begin
                    tick_next = tick_reg + 16'd1;
                end
            end
        endcase

        code_full       = 32'(active_row_reg) * 32'(COLS) + 32'(held_column_reg);
        result.key_code = result.key_valid ? code_full[CODE_W-1:0] : '0;
        for (int i = 0; i < ROW_W; i++)
        begin
            result.row_drive[i] = !(32'(active_row_next) == 32'(i));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SCAN;
            active_row_reg  <= '0;
            tick_reg        <= '0;
            held_column_reg <= '0;
            prev_cols_reg   <= COL_MASK;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            active_row_reg  <= active_row_next;
            tick_reg        <= tick_next;
            held_column_reg <= held_column_next;
            prev_cols_reg   <= cols;
        end
    end

`ifndef SYNTHESIS
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(active_row_reg) && $stable(tick_reg))
        else $error("state changed without an accepted sample");

    a_fall_debounces: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_SCAN && fell != '0 |=> phase_reg == PH_DEBOUNCE && tick_reg == '0)
        else $error("column fall did not start debouncing");

    a_report_resumes: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.key_valid |=> phase_reg == PH_SCAN && tick_reg == '0)
        else $error("key report did not return to scanning");

    a_row_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DEBOUNCE || phase_reg == PH_RELEASE |=> $stable(active_row_reg))
        else $error("row advanced outside scanning");
`endif

endmodule

### rtl/core/matrix_keypad_scanner.sv
// Top level of the matrix keypad scanner: configuration registers, request handshake and
// result register around mks_scan_core. Depends on mks_pkg and the interfaces in mks_if.
//
//   Channel  Direction  Carries                              Handshake
//   sample   in         column_levels                        valid / ready
//   result   out        row_drive, key_valid, key_code       valid / ready
//   cfg      in         cfg_index, cfg_data (write only)     cfg_we
//
// A new sample request is taken every cycle unless a stalled result keeps the result register full.
// The result of a sample appears on the next cycle from the result register.
// A stalled result holds the sample side only while the result register is full.
// Reset restores the scan state and loads scan_period 50 and debounce_time 5.
module matrix_keypad_scanner import mks_pkg::*; #(
    parameter int ROWS = MKS_ROWS,
    parameter int COLS = MKS_COLS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    mks_in_if.sink                sample,
    mks_out_if.source             result,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CFG_DATA_W-1:0] scan_period_reg;
    logic [CFG_DATA_W-1:0] debounce_time_reg;
    logic                  out_valid_reg, out_valid_next;
    mks_result_t           out_reg;
    mks_result_t           core_result;
    logic                  accept;

    assign sample.ready   = !out_valid_reg || result.ready;
    assign accept         = sample.valid && sample.ready;
    assign out_valid_next = accept || (out_valid_reg && !result.ready);

    mks_scan_core #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (accept),
        .scan_period   (scan_period_reg),
        .debounce_time (debounce_time_reg),
        .column_levels (sample.column_levels),
        .result        (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_period_reg   <= SCAN_PERIOD_RST;
            debounce_time_reg <= DEBOUNCE_TIME_RST;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SCAN_PERIOD:   scan_period_reg   <= cfg_data;
                    REG_DEBOUNCE_TIME: debounce_time_reg <= cfg_data;
                    default:           scan_period_reg   <= scan_period_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= core_result;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.row_drive = out_reg.row_drive;
    assign result.key_valid = out_reg.key_valid;
    assign result.key_code  = out_reg.key_code;

endmodule

### verif/matrix_keypad_scanner_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for matrix_keypad_scanner: column sample requests in, scan results out.
// Depends on mks_pkg and the mks_in_if / mks_out_if interfaces; keeps its own scanner model.
module matrix_keypad_scanner_tb;
    import mks_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mks_in_if  sample_if ();
    mks_out_if result_if ();

    matrix_keypad_scanner uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Scanner model state.
    logic [15:0]      m_period;
    logic [15:0]      m_debounce;
    phase_t           m_phase;
    logic [1:0]       m_row;
    logic [15:0]      m_tick;
    logic [1:0]       m_held;
    logic [COL_W-1:0] m_prev;

    mks_result_t pending_scan_results[$];
    int          err_count;
    int          sent_count;
    int          src_idle_pct;
    int          snk_idle_pct;
    int          hold_off_request;
    int          quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic load_reset_state();
        m_period   = SCAN_PERIOD_RST;
        m_debounce = DEBOUNCE_TIME_RST;
        m_phase    = PH_SCAN;
        m_row      = '0;
        m_tick     = '0;
        m_held     = '0;
        m_prev     = '1;
    endtask

    function automatic mks_result_t next_scan_result(input logic [COL_W-1:0] cols);
        mks_result_t      res;
        logic             held_bit;
        logic [COL_W-1:0] fell;
        int               lowest;
        res      = '0;
        held_bit = cols[m_held];
        lowest   = 0;
        case (m_phase)
            PH_DEBOUNCE:
            begin
                if (m_tick >= m_debounce)
                begin
                    m_tick  = '0;
                    m_phase = held_bit ? PH_SCAN : PH_RELEASE;
                end
                else
                begin
                    m_tick = m_tick + 16'd1;
                end
            end
            PH_RELEASE:
            begin
                if (held_bit)
                begin
                    res.key_valid = 1'b1;
                    res.key_code  = CODE_W'(int'(m_row) * MKS_COLS + int'(m_held));
                    m_phase       = PH_SCAN;
                    m_tick        = '0;
                end
            end
            default:
            begin
                m_phase = PH_SCAN;
                fell    = m_prev & ~cols;
                if (fell != '0)
                begin
                    for (int i = MKS_COLS - 1; i >= 0; i--)
                    begin
                        if (fell[i])
                            lowest = i;
                    end
                    m_held  = 2'(lowest);
                    m_phase = PH_DEBOUNCE;
                    m_tick  = '0;
                end
                else if ({1'b0, m_tick} + 17'd1 >= {1'b0, m_period})
                begin
                    m_tick = '0;
                    m_row  = (int'(m_row) == MKS_ROWS - 1) ? 2'd0 : m_row + 2'd1;
                end
                else
                begin
                    m_tick = m_tick + 16'd1;
                end
            end
        endcase
        m_prev        = cols;
        res.row_drive = ~(ROW_W'(1) << m_row);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // Result checking and request prediction share one sampling point per edge.
    always @(posedge clk)
    begin
        mks_result_t want;
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (pending_scan_results.size() == 0)
                begin
                    report_mismatch("unexpected result", 1, 0);
                end
                else
                begin
                    want = pending_scan_results.pop_front();
                    if (result_if.row_drive !== want.row_drive)
                        report_mismatch("row_drive", result_if.row_drive, want.row_drive);
                    if (result_if.key_valid !== want.key_valid)
                        report_mismatch("key_valid", result_if.key_valid, want.key_valid);
                    if (result_if.key_code !== want.key_code)
                        report_mismatch("key_code", result_if.key_code, want.key_code);
                end
            end
            if (sample_if.valid && sample_if.ready)
                pending_scan_results.push_back(next_scan_result(sample_if.column_levels));
        end
    end

    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request > 0)
            begin
                result_if.ready  <= 1'b0;
                hold_off_request = hold_off_request - 1;
            end
            else
            begin
                result_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("matrix_keypad_scanner_tb: done, errors");
            $finish;
        end
    end

    task automatic send_sample(input logic [COL_W-1:0] cols);
        while ($urandom_range(99) < src_idle_pct)
        begin
            sample_if.valid <= 1'b0;
            @(posedge clk);
        end
        sample_if.valid         <= 1'b1;
        sample_if.column_levels <= cols;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic send_repeat(input logic [COL_W-1:0] cols, input int count);
        repeat (count)
            send_sample(cols);
    endtask

    task automatic wait_drain();
        sample_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_scan_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic set_timing(input logic [15:0] period, input logic [15:0] debounce);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SCAN_PERIOD;
        cfg_data  <= period;
        @(posedge clk);
        cfg_index <= REG_DEBOUNCE_TIME;
        cfg_data  <= debounce;
        @(posedge clk);
        cfg_we     <= 1'b0;
        m_period   = period;
        m_debounce = debounce;
    endtask

    task automatic test_reset_defaults();
        send_repeat(4'hF, 4);
        send_repeat(4'hE, 2);
        wait_drain();
    endtask

    task automatic test_press_release();
        set_timing(16'd2, 16'd1);
        send_repeat(4'hF, 2);
        send_repeat(4'hE, 3);
        send_sample(4'hF);
        send_repeat(4'h7, 3);
        send_sample(4'hF);
        wait_drain();
    endtask

    task automatic test_bounce_and_multi();
        send_repeat(4'h0, 3);
        send_sample(4'h1);
        send_sample(4'hF);
        send_sample(4'hD);
        send_repeat(4'hF, 2);
        send_sample(4'hB);
        send_sample(4'h3);
        send_repeat(4'hB, 2);
        send_sample(4'hF);
        wait_drain();
    endtask

    task automatic test_zero_timing();
        set_timing(16'd0, 16'd0);
        send_repeat(4'hF, 5);
        send_repeat(4'hB, 2);
        send_sample(4'hF);
        send_sample(4'hE);
        send_sample(4'hF);
        wait_drain();
    endtask

    task automatic test_max_timing();
        set_timing(16'hFFFF, 16'hFFFF);
        send_repeat(4'hF, 4);
        send_repeat(4'h7, 4);
        send_repeat(4'hF, 2);
        wait_drain();
    endtask

    task automatic press_sequence();
        int               span;
        int               hold;
        int               kind;
        logic [COL_W-1:0] key;
        span = (m_period > 8) ? 8 : int'(m_period);
        send_repeat(4'hF, $urandom_range(0, (span + 1) * MKS_ROWS));
        key  = COL_W'($urandom_range(0, 14));
        kind = $urandom_range(0, 9);
        hold = $urandom_range(0, ((m_debounce > 8) ? 8 : int'(m_debounce)) + 3);
        repeat (hold + 1)
        begin
            if (kind == 0)
                send_sample(COL_W'($urandom_range(0, 15)));
            else
                send_sample(key);
        end
        if (kind == 1)
            send_sample(key | COL_W'($urandom_range(0, 15)));
        send_sample(4'hF);
    endtask

    task automatic run_random_phase(input int n_items, input int src_pct, input int snk_pct,
                                    input logic [15:0] period, input logic [15:0] debounce);
        int target;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        set_timing(period, debounce);
        target = sent_count + n_items;
        while (sent_count < target)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    send_sample(COL_W'($urandom_range(0, 15)));
            end
            else
            begin
                press_sequence();
            end
        end
        wait_drain();
    endtask

    task automatic test_backpressure();
        set_timing(16'd3, 16'd2);
        hold_off_request = 300;
        repeat (4)
            press_sequence();
        wait_drain();
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = REG_SCAN_PERIOD;
        cfg_data                = '0;
        sample_if.valid         = 1'b0;
        sample_if.column_levels = '1;
        err_count               = 0;
        sent_count              = 0;
        src_idle_pct            = 20;
        snk_idle_pct            = 72;
        hold_off_request        = 0;
        quiet_cycles            = 0;
        load_reset_state();
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_press_release();
        test_bounce_and_multi();
        test_zero_timing();
        test_max_timing();
        run_random_phase(580, 20, 72, 16'($urandom_range(1, 6)), 16'($urandom_range(0, 5)));
        run_random_phase(580, 72, 20, 16'($urandom_range(1, 6)), 16'($urandom_range(0, 5)));
        run_random_phase(500, 0, 0, 16'($urandom_range(1, 6)), 16'($urandom_range(0, 5)));
        test_backpressure();
        wait_drain();

        if (err_count == 0)
            $display("matrix_keypad_scanner_tb: done, clean");
        else
            $display("matrix_keypad_scanner_tb: done, errors");
        $finish;
    end

endmodule
